FILE: design/checked_integer_operator_unit_defines.svh
// Assertion macros for the checked integer operator unit.
`ifndef CHECKED_INTEGER_OPERATOR_UNIT_DEFINES_SVH
`define CHECKED_INTEGER_OPERATOR_UNIT_DEFINES_SVH
`ifndef SYNTH
`define CIOU_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
		else $error("ciou assertion failed");
`define CIOU_ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) else $error("ciou assertion failed");
`else
`define CIOU_ASSERT(lbl, clk, rstn, prop)
`define CIOU_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

FILE: design/ciou_pkg.sv
package ciou_pkg;

	localparam int unsigned DataW = 64;
	localparam int unsigned OpW = 4;
	localparam int unsigned CntW = 6;
	localparam int unsigned FactW = 5;
	localparam logic [FactW-1:0] FactMax = FactW'(20);
	localparam logic [DataW-1:0] MinVal = {1'b1, {(DataW-1){1'b0}}};
	localparam logic [DataW-1:0] MaxPos = {1'b0, {(DataW-1){1'b1}}};
	localparam logic [DataW-1:0] AllOnes = {DataW{1'b1}};

	typedef enum logic [OpW-1:0] {
		OP_ADD  = 4'd0,
		OP_SUB  = 4'd1,
		OP_MUL  = 4'd2,
		OP_DIV  = 4'd3,
		OP_MOD  = 4'd4,
		OP_POW  = 4'd5,
		OP_GCD  = 4'd6,
		OP_LCM  = 4'd7,
		OP_FACT = 4'd8
	} op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL_W,
		ST_DIV_W,
		ST_POW,
		ST_POW_ODD_W,
		ST_POW_SQ,
		ST_POW_SQ_W,
		ST_POW_LAST_W,
		ST_GCD,
		ST_GCD_W,
		ST_LCM_DIV_W,
		ST_LCM_MUL_W,
		ST_FACT,
		ST_FACT_W
	} state_t;

	typedef struct packed {
		logic             start;
		logic             div;
		logic [DataW-1:0] x;
		logic [DataW-1:0] y;
	} mdu_cmd_t;

	typedef struct packed {
		logic             busy;
		logic             done;
		logic [DataW-1:0] hi;
		logic [DataW-1:0] lo;
	} mdu_sts_t;

	function automatic logic [DataW-1:0] mag64(input logic [DataW-1:0] v);
		return v[DataW-1] ? (~v + DataW'(1)) : v;
	endfunction

	// Returns {ok, value} for a full unsigned product and the sign of the result.
	function automatic logic [DataW:0] chk_mul(input logic [2*DataW-1:0] p, input logic neg);
		logic [DataW-1:0] lo;
		logic             ok;
		lo = p[DataW-1:0];
		ok = (p[2*DataW-1:DataW] == '0) && (neg ? (lo <= MinVal) : (lo <= MaxPos));
		return {ok, neg ? (~lo + DataW'(1)) : lo};
	endfunction

endpackage

FILE: design/checked_integer_operator_unit.sv
// Channel   Handshake        Ports
// command   start / busy     operation, left_value, right_value
// result    done strobe      result_value, error
//
// Add and subtract finish directly from the idle state. Multiply, divide and modulo
// take one pass of the bit-serial multiply/divide unit (one bit a cycle).
// Power takes up to 125 such passes, GCD one pass per Euclid step, LCM the
// GCD steps plus two passes, factorial up to 19 passes.
// Reset clears the sequencer and the unit; the receiver cannot stall, and done
// is high for one cycle with each word.
`include "checked_integer_operator_unit_defines.svh"
module checked_integer_operator_unit import ciou_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  logic [OpW-1:0]   operation,
	input  logic [DataW-1:0] left_value,
	input  logic [DataW-1:0] right_value,
	output logic             done,
	output logic [DataW-1:0] result_value,
	output logic             error
);

	state_t           state_q, state_d;
	logic [OpW-1:0]   op_q, op_d;
	logic [DataW-1:0] x_q, x_d, y_q, y_d, e_q, e_d, ul_q, ul_d, ur_q, ur_d;
	logic             neg_q, neg_d, lneg_q, lneg_d;
	logic [FactW-1:0] i_q, i_d, n_q, n_d;
	logic             done_q, error_q;
	logic [DataW-1:0] result_q;
	logic             fin, fin_err;
	logic [DataW-1:0] fin_val;
	mdu_cmd_t         cmd;
	mdu_sts_t         sts;
	logic [DataW:0]   pr;
	logic [DataW-1:0] sum, dif, ul, ur;

	ciou_mdu u_mdu (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.sts    (sts)
	);

	always_comb begin
		ul  = mag64(left_value);
		ur  = mag64(right_value);
		sum = left_value + right_value;
		dif = left_value - right_value;
		pr  = chk_mul({sts.hi, sts.lo}, neg_q);
	end

	always_comb begin
		state_d = state_q;
		op_d = op_q; x_d = x_q; y_d = y_q; e_d = e_q; ul_d = ul_q; ur_d = ur_q;
		neg_d = neg_q; lneg_d = lneg_q; i_d = i_q; n_d = n_q;
		fin = 1'b0; fin_err = 1'b0; fin_val = '0;
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					op_d   = operation;
					ul_d   = ul;
					ur_d   = ur;
					lneg_d = left_value[DataW-1];
					neg_d  = left_value[DataW-1] ^ right_value[DataW-1];
					case (operation)
						OP_ADD: begin
							fin = 1'b1;
							fin_err = (left_value[DataW-1] == right_value[DataW-1]) &&
								(sum[DataW-1] != left_value[DataW-1]);
							fin_val = sum;
						end
						OP_SUB: begin
							fin = 1'b1;
							fin_err = (left_value[DataW-1] != right_value[DataW-1]) &&
								(dif[DataW-1] != left_value[DataW-1]);
							fin_val = dif;
						end
						OP_MUL: begin
							cmd = '{start: 1'b1, div: 1'b0, x: ul, y: ur};
							state_d = ST_MUL_W;
						end
						OP_DIV, OP_MOD: begin
							if (right_value == '0) begin
								fin = 1'b1;
							end else if (left_value == MinVal && right_value == AllOnes) begin
								fin = 1'b1;
								fin_err = 1'b1;
							end else begin
								cmd = '{start: 1'b1, div: 1'b1, x: ul, y: ur};
								state_d = ST_DIV_W;
							end
						end
						OP_POW: begin
							if (right_value[DataW-1]) begin
								fin = 1'b1;
								fin_err = 1'b1;
							end else if (right_value == '0) begin
								fin = 1'b1;
								fin_val = DataW'(1);
							end else begin
								x_d = DataW'(1);
								y_d = left_value;
								e_d = right_value;
								state_d = ST_POW;
							end
						end
						OP_GCD, OP_LCM: begin
							if ((operation == OP_GCD) ? (ul == '0 && ur == '0)
									: (ul == '0 || ur == '0)) begin
								fin = 1'b1;
							end else begin
								x_d = ul;
								y_d = ur;
								state_d = ST_GCD;
							end
						end
						OP_FACT: begin
							if (left_value[DataW-1] ||
									left_value[DataW-2:0] > (DataW-1)'(FactMax)) begin
								fin = 1'b1;
								fin_err = 1'b1;
							end else begin
								x_d = DataW'(1);
								i_d = FactW'(2);
								n_d = left_value[FactW-1:0];
								state_d = ST_FACT;
							end
						end
						default: begin
							fin = 1'b1;
							fin_err = 1'b1;
						end
					endcase
				end
			end
			ST_MUL_W, ST_POW_LAST_W, ST_LCM_MUL_W: begin
				if (sts.done) begin
					fin = 1'b1;
					fin_err = !pr[DataW];
					fin_val = pr[DataW] ? pr[DataW-1:0] : '0;
					state_d = ST_IDLE;
				end
			end
			ST_DIV_W: begin
				if (sts.done) begin
					fin = 1'b1;
					if (op_q == OP_DIV) begin
						fin_val = neg_q ? (~sts.lo + DataW'(1)) : sts.lo;
					end else begin
						fin_val = lneg_q ? (~sts.hi + DataW'(1)) : sts.hi;
					end
					state_d = ST_IDLE;
				end
			end
			ST_POW: begin
				neg_d = x_q[DataW-1] ^ y_q[DataW-1];
				if (e_q > DataW'(1)) begin
					if (e_q[0]) begin
						cmd = '{start: 1'b1, div: 1'b0, x: mag64(x_q), y: mag64(y_q)};
						state_d = ST_POW_ODD_W;
					end else begin
						state_d = ST_POW_SQ;
					end
				end else begin
					cmd = '{start: 1'b1, div: 1'b0, x: mag64(x_q), y: mag64(y_q)};
					state_d = ST_POW_LAST_W;
				end
			end
			ST_POW_ODD_W: begin
				if (sts.done) begin
					if (pr[DataW]) begin
						x_d = pr[DataW-1:0];
						state_d = ST_POW_SQ;
					end else begin
						fin = 1'b1;
						fin_err = 1'b1;
						state_d = ST_IDLE;
					end
				end
			end
			ST_POW_SQ: begin
				e_d = e_q >> 1;
				neg_d = 1'b0;
				cmd = '{start: 1'b1, div: 1'b0, x: mag64(y_q), y: mag64(y_q)};
				state_d = ST_POW_SQ_W;
			end
			ST_POW_SQ_W: begin
				if (sts.done) begin
					if (pr[DataW]) begin
						y_d = pr[DataW-1:0];
						state_d = ST_POW;
					end else begin
						fin = 1'b1;
						fin_err = 1'b1;
						state_d = ST_IDLE;
					end
				end
			end
			ST_GCD: begin
				if (y_q == '0) begin
					if (op_q == OP_LCM) begin
						cmd = '{start: 1'b1, div: 1'b1, x: ul_q, y: x_q};
						state_d = ST_LCM_DIV_W;
					end else begin
						fin = 1'b1;
						fin_err = x_q > MaxPos;
						fin_val = (x_q > MaxPos) ? '0 : x_q;
						state_d = ST_IDLE;
					end
				end else begin
					cmd = '{start: 1'b1, div: 1'b1, x: x_q, y: y_q};
					state_d = ST_GCD_W;
				end
			end
			ST_GCD_W: begin
				if (sts.done) begin
					x_d = y_q;
					y_d = sts.hi;
					state_d = ST_GCD;
				end
			end
			ST_LCM_DIV_W: begin
				if (sts.done) begin
					neg_d = 1'b0;
					cmd = '{start: 1'b1, div: 1'b0, x: sts.lo, y: ur_q};
					state_d = ST_LCM_MUL_W;
				end
			end
			ST_FACT: begin
				neg_d = 1'b0;
				if (i_q > n_q) begin
					fin = 1'b1;
					fin_val = x_q;
					state_d = ST_IDLE;
				end else begin
					cmd = '{start: 1'b1, div: 1'b0, x: x_q, y: DataW'(i_q)};
					state_d = ST_FACT_W;
				end
			end
			ST_FACT_W: begin
				if (sts.done) begin
					x_d = sts.lo;
					i_d = i_q + FactW'(1);
					state_d = ST_FACT;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= fin;
		end
	end

	always_ff @(posedge clk) begin
		op_q   <= op_d;
		x_q    <= x_d;
		y_q    <= y_d;
		e_q    <= e_d;
		ul_q   <= ul_d;
		ur_q   <= ur_d;
		neg_q  <= neg_d;
		lneg_q <= lneg_d;
		i_q    <= i_d;
		n_q    <= n_d;
		if (fin) begin
			error_q  <= fin_err;
			result_q <= fin_err ? '0 : fin_val;
		end
	end

	assign busy         = (state_q != ST_IDLE);
	assign done         = done_q;
	assign result_value = result_q;
	assign error        = error_q;

	`CIOU_ASSERT(a_err_zero, clk, arst_n, (done && error) |-> (result_value == '0))
	`CIOU_ASSERT(a_start_free, clk, arst_n, cmd.start |-> !sts.busy)
	`CIOU_ASSERT(a_done_waits, clk, arst_n, sts.done |-> (state_q != ST_IDLE))

endmodule

FILE: design/ciou_mdu.sv
module ciou_mdu import ciou_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  mdu_cmd_t cmd,
	output mdu_sts_t sts
);

	logic             busy_q, div_q, done_q;
	logic [CntW-1:0]  cnt_q;
	logic [DataW-1:0] hi_q, lo_q, y_q;
	logic [DataW:0]   a, b;
	logic [DataW+1:0] s;
	logic             ge;

	// One 66-bit adder serves both the shift-add multiply and the restoring divide.
	always_comb begin
		a = div_q ? {hi_q, lo_q[DataW-1]} : {1'b0, hi_q};
		b = (div_q || lo_q[0]) ? {1'b0, y_q} : '0;
		s = {1'b0, a} + {1'b0, div_q ? ~b : b} + {{(DataW+1){1'b0}}, div_q};
		ge = s[DataW+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			div_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == {CntW{1'b1}});
			if (cmd.start) begin
				busy_q <= 1'b1;
				div_q  <= cmd.div;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CntW'(1);
				if (cnt_q == {CntW{1'b1}}) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			hi_q <= '0;
			lo_q <= cmd.x;
			y_q  <= cmd.y;
		end else if (busy_q) begin
			if (div_q) begin
				hi_q <= ge ? s[DataW-1:0] : a[DataW-1:0];
				lo_q <= {lo_q[DataW-2:0], ge};
			end else begin
				hi_q <= s[DataW:1];
				lo_q <= {s[0], lo_q[DataW-1:1]};
			end
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign sts.hi   = hi_q;
	assign sts.lo   = lo_q;

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps
module tb;
	import ciou_pkg::*;

	localparam int unsigned CycleLimit = 30000000;

	logic             clk;
	logic             arst_n;
	logic             start;
	logic             busy;
	logic [OpW-1:0]   operation;
	logic [DataW-1:0] left_value;
	logic [DataW-1:0] right_value;
	logic             done;
	logic [DataW-1:0] result_value;
	logic             error;

	typedef struct {
		logic [DataW-1:0] value;
		logic             err;
	} outcome_t;

	outcome_t    pending_outcomes[$];
	int unsigned mismatch_count;
	int unsigned cycle_count;

	checked_integer_operator_unit dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.operation(operation), .left_value(left_value), .right_value(right_value),
		.done(done), .result_value(result_value), .error(error)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic logic is_neg(input logic [DataW-1:0] v);
		return v[DataW-1];
	endfunction

	function automatic logic [DataW-1:0] magnitude(input logic [DataW-1:0] v);
		return is_neg(v) ? (~v + 64'd1) : v;
	endfunction

	// Signed multiply with overflow detection; returns ok.
	function automatic logic signed_mul(input logic [DataW-1:0] a, input logic [DataW-1:0] b,
			output logic [DataW-1:0] r);
		logic [2*DataW-1:0] p;
		logic               neg;
		p = {64'd0, magnitude(a)} * {64'd0, magnitude(b)};
		neg = is_neg(a) != is_neg(b);
		r = '0;
		if (p[2*DataW-1:DataW] != '0) return 1'b0;
		if (neg) begin
			if (p[DataW-1:0] > MinVal) return 1'b0;
			r = ~p[DataW-1:0] + 64'd1;
		end else begin
			if (p[DataW-1:0] > MaxPos) return 1'b0;
			r = p[DataW-1:0];
		end
		return 1'b1;
	endfunction

	function automatic logic [DataW-1:0] euclid(input logic [DataW-1:0] a, input logic [DataW-1:0] b);
		logic [DataW-1:0] t;
		while (b != 0) begin
			t = b;
			b = a % b;
			a = t;
		end
		return a;
	endfunction

	function automatic outcome_t predict_outcome(input logic [OpW-1:0] op,
			input logic [DataW-1:0] l, input logic [DataW-1:0] r);
		outcome_t         o;
		logic             ok;
		logic [DataW-1:0] v, ul, ur, s, g, acc, b, e;
		logic [2*DataW-1:0] wide;
		ul = magnitude(l);
		ur = magnitude(r);
		v = '0;
		ok = 1'b1;
		case (op)
			OP_ADD: begin
				v = l + r;
				ok = !(is_neg(l) == is_neg(r) && is_neg(v) != is_neg(l));
			end
			OP_SUB: begin
				v = l - r;
				ok = !(is_neg(l) != is_neg(r) && is_neg(v) != is_neg(l));
			end
			OP_MUL: ok = signed_mul(l, r, v);
			OP_DIV, OP_MOD: begin
				if (r == 0) v = '0;
				else if (l == MinVal && r == AllOnes) ok = 1'b0;
				else if (op == OP_DIV) begin
					s = ul / ur;
					v = (is_neg(l) != is_neg(r)) ? -s : s;
				end else begin
					s = ul % ur;
					v = is_neg(l) ? -s : s;
				end
			end
			OP_POW: begin
				if (is_neg(r)) ok = 1'b0;
				else if (r == 0) v = 64'd1;
				else begin
					acc = 64'd1;
					b = l;
					e = r;
					while (ok && e > 1) begin
						if (e[0]) ok = signed_mul(acc, b, acc);
						e = e >> 1;
						if (ok) ok = signed_mul(b, b, b);
					end
					if (ok) ok = signed_mul(acc, b, v);
				end
			end
			OP_GCD: begin
				if (ul != 0 || ur != 0) begin
					g = euclid(ul, ur);
					ok = g <= MaxPos;
					v = g;
				end
			end
			OP_LCM: begin
				if (ul != 0 && ur != 0) begin
					g = euclid(ul, ur);
					wide = {64'd0, ul / g} * {64'd0, ur};
					ok = wide[2*DataW-1:DataW] == '0 && wide[DataW-1:0] <= MaxPos;
					v = wide[DataW-1:0];
				end
			end
			OP_FACT: begin
				if (is_neg(l) || l > 20) ok = 1'b0;
				else begin
					v = 64'd1;
					for (int i = 2; i <= l; i++) v = v * i;
				end
			end
			default: ok = 1'b0;
		endcase
		o.value = ok ? v : '0;
		o.err = !ok;
		return o;
	endfunction

	// A nonzero gap drops start before waiting.
	task automatic idle_cycles(input int unsigned n);
		if (n != 0) start <= 1'b0;
		repeat (n) @(negedge clk);
	endtask

	function automatic int unsigned random_gap();
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 50) return 0;
		if (pick < 92) return $urandom_range(1, 4);
		return $urandom_range(20, 150);
	endfunction

	// Sends one word; called and returns at a falling edge. Start stays high on
	// return so that the next word can follow at once.
	task automatic send_word(input logic [OpW-1:0] op, input logic [DataW-1:0] l,
			input logic [DataW-1:0] r);
		start <= 1'b1;
		operation <= op;
		left_value <= l;
		right_value <= r;
		do @(posedge clk); while (busy);
		pending_outcomes.push_back(predict_outcome(op, l, r));
		@(negedge clk);
	endtask

	task automatic drain_outcomes();
		start <= 1'b0;
		do @(negedge clk); while (pending_outcomes.size() != 0);
	endtask

	function automatic logic [DataW-1:0] random_operand();
		int unsigned pick;
		logic [DataW-1:0] v;
		pick = $urandom_range(9);
		v = {$urandom(), $urandom()};
		case (pick)
			0, 1: return v;
			2: return v >> $urandom_range(1, 63);
			3: return -(v >> $urandom_range(1, 63));
			4: return 64'($signed($urandom_range(0, 40)) - 20);
			5: return MinVal;
			6: return MaxPos;
			7: return {$urandom_range(1) ? MinVal : 64'd0} | 64'($urandom_range(3));
			default: return 64'($signed($urandom_range(0, 4000)) - 2000);
		endcase
	endfunction

	task automatic test_directed();
		send_word(OP_ADD, MaxPos, 64'd1);
		send_word(OP_ADD, MinVal, AllOnes);
		send_word(OP_ADD, AllOnes, 64'd1);
		send_word(OP_SUB, MinVal, 64'd1);
		send_word(OP_SUB, MaxPos, AllOnes);
		send_word(OP_MUL, MinVal, 64'd1);
		send_word(OP_MUL, MinVal, AllOnes);
		send_word(OP_MUL, 64'h0000_0001_0000_0000, 64'hFFFF_FFFF_0000_0000);
		send_word(OP_DIV, 64'd17, 64'd0);
		send_word(OP_DIV, MinVal, AllOnes);
		send_word(OP_DIV, -64'd7, 64'd2);
		send_word(OP_MOD, -64'd7, 64'd2);
		send_word(OP_MOD, MinVal, AllOnes);
		send_word(OP_MOD, 64'd5, 64'd0);
		send_word(OP_POW, 64'd0, 64'd0);
		send_word(OP_POW, 64'd2, AllOnes);
		send_word(OP_POW, -64'd2, 64'd63);
		send_word(OP_POW, 64'd2, 64'd63);
		send_word(OP_POW, AllOnes, MaxPos);
		send_word(OP_GCD, 64'd0, 64'd0);
		send_word(OP_GCD, MinVal, 64'd0);
		send_word(OP_LCM, 64'd0, 64'd5);
		send_word(OP_LCM, MinVal, 64'd3);
		send_word(OP_FACT, 64'd20, 64'd0);
		send_word(OP_FACT, 64'd21, AllOnes);
		send_word(OP_FACT, AllOnes, 64'd0);
		send_word(OP_FACT, 64'd0, MaxPos);
		send_word(4'hF, MaxPos, MinVal);
	endtask

	task automatic test_random(input int unsigned count);
		logic [OpW-1:0]   op;
		logic [DataW-1:0] l, r;
		for (int unsigned i = 0; i < count; i++) begin
			if (i == count / 2) drain_outcomes();
			op = ($urandom_range(19) == 0) ? 4'($urandom_range(9, 15))
				: 4'($urandom_range(0, 8));
			l = random_operand();
			r = random_operand();
			if (op == OP_POW && $urandom_range(3) != 0) r = 64'($urandom_range(0, 70));
			if (op == OP_FACT && $urandom_range(3) != 0) l = 64'($urandom_range(0, 24));
			send_word(op, l, r);
			idle_cycles(random_gap());
		end
	endtask

	always @(posedge clk) begin
		outcome_t exp_o;
		cycle_count <= cycle_count + 1;
		if (arst_n && done) begin
			if (pending_outcomes.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected word: result %h error %b", result_value, error);
			end else begin
				exp_o = pending_outcomes.pop_front();
				if (result_value !== exp_o.value || error !== exp_o.err) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("mismatch: expected %h/%b got %h/%b",
							exp_o.value, exp_o.err, result_value, error);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (cycle_count >= CycleLimit) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		mismatch_count = 0;
		cycle_count = 0;
		arst_n = 1'b0;
		start = 1'b0;
		operation = '0;
		left_value = '0;
		right_value = '0;
		idle_cycles(2);
		arst_n <= 1'b1;
		idle_cycles(2);
		test_directed();
		test_random(600);
		drain_outcomes();
		idle_cycles(300);
		if (mismatch_count == 0 && pending_outcomes.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end
endmodule

FILE: checked_integer_operator_unit.f
+incdir+design
design/ciou_pkg.sv
design/ciou_mdu.sv
design/checked_integer_operator_unit.sv
verif/tb.sv
